// ===== design/mks_pkg.sv =====
// Shared types and constants of the 4x3 matrix keypad scanner.
// Holds the result bundle type and the key map; no dependencies.
package mks_pkg;

	localparam int unsigned ROWS_W = 4;
	localparam int unsigned COLS_W = 3;
	localparam int unsigned CODE_W = 8;
	localparam int unsigned DEB_W  = 16;

	localparam logic [DEB_W-1:0]  DEBOUNCE_RESET = 16'd1311;
	localparam logic [ROWS_W-1:0] ALL_ROWS       = 4'hF;
	localparam logic [CODE_W-1:0] KEY_NONE       = 8'h30;

	typedef struct packed {
		logic [ROWS_W-1:0] row_drive;
		logic              key_valid;
		logic [CODE_W-1:0] key_code;
	} mks_result_t;

	function automatic logic [CODE_W-1:0] key_lookup(input logic [1:0] row,
		input logic [1:0] col);
		logic [CODE_W-1:0] code;
		unique case ({row, col})
			4'b00_00: code = 8'h2A;
			4'b00_01: code = 8'h30;
			4'b00_10: code = 8'h23;
			4'b01_00: code = 8'h37;
			4'b01_01: code = 8'h38;
			4'b01_10: code = 8'h39;
			4'b10_00: code = 8'h34;
			4'b10_01: code = 8'h35;
			4'b10_10: code = 8'h36;
			4'b11_00: code = 8'h31;
			4'b11_01: code = 8'h32;
			4'b11_10: code = 8'h33;
			default:  code = KEY_NONE;
		endcase
		return code;
	endfunction

endpackage

// ===== design/mks_fsm.sv =====
// Scan and debounce state machine of the keypad scanner, one step per tick.
// Depends on mks_pkg for the result type and the key map.
module mks_fsm (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     step_en,
	input  logic [mks_pkg::COLS_W-1:0] col_sense,
	input  logic                     cfg_we,
	input  logic [mks_pkg::DEB_W-1:0]  cfg_wdata,
	output mks_pkg::mks_result_t     result
);
	import mks_pkg::*;

	localparam logic [2:0] PH_WAIT_PRESS   = 3'd0;
	localparam logic [2:0] PH_DEB_PRESS    = 3'd1;
	localparam logic [2:0] PH_SCAN         = 3'd2;
	localparam logic [2:0] PH_HOLD_CHECK   = 3'd3;
	localparam logic [2:0] PH_WAIT_RELEASE = 3'd4;
	localparam logic [2:0] PH_DEB_RELEASE  = 3'd5;

	logic [DEB_W-1:0]  ticks_q;
	logic [2:0]        phase_q, phase_d;
	logic [DEB_W-1:0]  count_q, count_d;
	logic [1:0]        row_q, row_d;
	logic [CODE_W-1:0] key_q, key_d;
	logic [COLS_W-1:0] prev_q;
	logic              rise, fall, any_col, edge_hit, expired;
	logic [1:0]        col_idx;
	logic [DEB_W-1:0]  deb_count;

	assign rise    = |(col_sense & ~prev_q);
	assign fall    = |(prev_q & ~col_sense);
	assign any_col = |col_sense;

	always_comb begin
		priority if (col_sense[0]) begin
			col_idx = 2'd0;
		end else if (col_sense[1]) begin
			col_idx = 2'd1;
		end else begin
			col_idx = 2'd2;
		end
	end

	assign edge_hit = (phase_q == PH_DEB_RELEASE) ? fall : rise;

	always_comb begin
		expired   = 1'b0;
		deb_count = count_q - DEB_W'(1);
		priority if (edge_hit) begin
			deb_count = ticks_q;
		end else if (count_q <= DEB_W'(1)) begin
			deb_count = '0;
			expired   = 1'b1;
		end
	end

	always_comb begin
		phase_d          = phase_q;
		count_d          = count_q;
		row_d            = row_q;
		key_d            = key_q;
		result.row_drive = ALL_ROWS;
		result.key_valid = 1'b0;
		result.key_code  = '0;
		unique case (phase_q)
			PH_WAIT_PRESS: begin
				if (rise) begin
					count_d = ticks_q;
					phase_d = PH_DEB_PRESS;
				end
			end
			PH_DEB_PRESS: begin
				count_d = deb_count;
				if (expired) begin
					row_d   = '0;
					phase_d = any_col ? PH_SCAN : PH_WAIT_PRESS;
				end
			end
			PH_SCAN: begin
				result.row_drive = ROWS_W'(1) << row_q;
				if (any_col) begin
					key_d   = key_lookup(row_q, col_idx);
					phase_d = PH_HOLD_CHECK;
				end else if (row_q == 2'd3) begin
					key_d   = KEY_NONE;
					phase_d = PH_HOLD_CHECK;
				end else begin
					row_d = row_q + 2'd1;
				end
			end
			PH_HOLD_CHECK: begin
				phase_d = any_col ? PH_WAIT_RELEASE : PH_WAIT_PRESS;
			end
			PH_WAIT_RELEASE: begin
				if (fall) begin
					count_d = ticks_q;
					phase_d = PH_DEB_RELEASE;
				end
			end
			PH_DEB_RELEASE: begin
				count_d = deb_count;
				if (expired) begin
					if (!any_col) begin
						result.key_valid = 1'b1;
						result.key_code  = key_q;
						phase_d          = PH_WAIT_PRESS;
					end else begin
						phase_d = PH_WAIT_RELEASE;
					end
				end
			end
			default: begin
				phase_d = PH_WAIT_PRESS;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= DEBOUNCE_RESET;
		end else if (cfg_we) begin
			ticks_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WAIT_PRESS;
			count_q <= '0;
			row_q   <= '0;
			key_q   <= KEY_NONE;
			prev_q  <= '0;
		end else if (step_en) begin
			phase_q <= phase_d;
			count_q <= count_d;
			row_q   <= row_d;
			key_q   <= key_d;
			prev_q  <= col_sense;
		end
	end

	a_report_on_release: assert property (@(posedge clk) disable iff (!arst_n)
		result.key_valid |-> (phase_q == PH_DEB_RELEASE) && !any_col)
		else $error("key reported outside a confirmed release");

	a_rows_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_SCAN) |-> $onehot(result.row_drive))
		else $error("row drive not one-hot while scanning");

	a_press_arms_count: assert property (@(posedge clk) disable iff (!arst_n)
		step_en && (phase_q == PH_WAIT_PRESS) && rise
		|=> (phase_q == PH_DEB_PRESS) && (count_q == $past(ticks_q)))
		else $error("press edge did not arm the debounce count");

endmodule

// ===== design/matrix_keypad_scanner.sv =====
// A transaction passes through the input register and then the result register.
// Throughput: one transaction per cycle while out_ready is high; the result register
// frees as soon as it is taken. The step logic between the two registers is one state
// update of the scan machine. Reset (arst_n low, asynchronous): waiting for a press,
// debounce period 1311 ticks, no transaction held in either register.
module matrix_keypad_scanner (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [mks_pkg::COLS_W-1:0] col_sense,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [mks_pkg::ROWS_W-1:0] row_drive,
	output logic                       key_valid,
	output logic [mks_pkg::CODE_W-1:0] key_code,
	input  logic                       cfg_we,
	input  logic [mks_pkg::DEB_W-1:0]  cfg_wdata
);
	import mks_pkg::*;

	logic              valid_s1;
	logic [COLS_W-1:0] col_sense_s1;
	logic              valid_s2;
	mks_result_t       result_s2;
	mks_result_t       step_result;
	logic              advance;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			col_sense_s1 <= col_sense;
		end
	end

	mks_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step_en   (advance),
		.col_sense (col_sense_s1),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (step_result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_s2 <= step_result;
		end
	end

	assign out_valid = valid_s2;
	assign row_drive = result_s2.row_drive;
	assign key_valid = result_s2.key_valid;
	assign key_code  = result_s2.key_code;

	a_ready_follows_sink: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input stalled while the result side is ready");

endmodule
